// ===== hdl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, constants and helper functions of the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX_X   = 3'd2,
        MODE_OCT     = 3'd3,
        MODE_U_START = 3'd4,
        MODE_U_FOUR  = 3'd5,
        MODE_U_BRACE = 3'd6
    } mode_t;

    localparam logic [3:0] MAX_BRACE_DIGITS = 4'd8;
    localparam logic [3:0] HEX_X_DIGITS     = 4'd2;
    localparam logic [3:0] U_FOUR_DIGITS    = 4'd4;
    localparam logic [3:0] OCT_DIGITS       = 4'd3;
    localparam int         MAX_RESULTS      = 4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;

    localparam logic [7:0] BEL = 8'd7;
    localparam logic [7:0] BS  = 8'd8;
    localparam logic [7:0] HT  = 8'd9;
    localparam logic [7:0] LF  = 8'd10;
    localparam logic [7:0] VT  = 8'd11;
    localparam logic [7:0] FF  = 8'd12;
    localparam logic [7:0] CR  = 8'd13;

    localparam logic [31:0] CP_MAX         = 32'h0010_FFFF;
    localparam logic [31:0] CP_REPLACEMENT = 32'h0000_FFFD;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_t;

    function automatic hex_t hex_val(input logic [7:0] ch);
        hex_t r;
        r = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(ch - 8'h57);
        end
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [31:0] cp);
        utf8_t       r;
        logic [31:0] c;
        c = (cp > CP_MAX) ? CP_REPLACEMENT : cp;
        r = '0;
        if (c < 32'h80) begin
            r.len  = 3'd1;
            r.b[0] = c[7:0];
        end else if (c < 32'h800) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, c[10:6]};
            r.b[1] = {2'b10, c[5:0]};
        end else if (c < 32'h1_0000) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, c[15:12]};
            r.b[1] = {2'b10, c[11:6]};
            r.b[2] = {2'b10, c[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, c[20:18]};
            r.b[1] = {2'b10, c[17:12]};
            r.b[2] = {2'b10, c[11:6]};
            r.b[3] = {2'b10, c[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== hdl/sed_in_if.sv =====
// ----------------------------------------------------------------------------
// sed_in_if
// Raw string body channel: one byte per word, flag on the last byte.
// ----------------------------------------------------------------------------
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== hdl/sed_out_if.sv =====
// ----------------------------------------------------------------------------
// sed_out_if
// Decoded byte channel: one byte per word, flag on the last byte of a run.
// ----------------------------------------------------------------------------
interface sed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hdl/string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes C and JavaScript string escapes, one raw byte per input word.
// ----------------------------------------------------------------------------
// Each input word passes an input register, is decoded combinationally into a
// four-byte result buffer, and the buffer drains one byte per output word.
// An input word that yields zero or one byte does not hold the input, so such
// words stream at one per cycle while the output is ready; a word that yields
// k bytes (up to four, for a UTF-8 sequence or a flushed octal escape) holds
// the input while the single-byte output port drains the buffer, until its
// last byte is taken. Every result run ends with run_last set on its last
// byte; a word that yields nothing gives no output word.
module string_escape_decoder (
    input  logic         clk,
    input  logic         rst_n,
    sed_in_if.sink       text,
    sed_out_if.source    decoded
);

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_byte_reg;
    logic                 s1_eos_reg;

    sed_pkg::mode_t       mode_reg, mode_next;
    logic [31:0]          acc_reg, acc_next;
    logic [3:0]           digits_reg, digits_next;
    logic                 stop_reg, stop_next;

    logic [3:0][7:0]      buf_reg, buf_next;
    logic [2:0]           cnt_reg, cnt_next;

    logic [3:0][7:0]      res;
    logic [2:0]           rn;
    sed_pkg::hex_t        hx;
    sed_pkg::utf8_t       enc;

    logic                 load;
    logic                 take;

    assign take  = (cnt_reg != 3'd0) && decoded.ready;
    assign load  = s1_valid_reg &&
                   ((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && decoded.ready));
    assign text.ready = !s1_valid_reg || load;

    assign decoded.valid    = (cnt_reg != 3'd0);
    assign decoded.out_byte = buf_reg[0];
    assign decoded.run_last = (cnt_reg == 3'd1);

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        stop_next   = stop_reg;
        res         = '0;
        rn          = 3'd0;
        enc         = '0;
        hx          = sed_pkg::hex_val(s1_byte_reg);

        unique case (mode_reg)
            sed_pkg::MODE_ESC:
            begin
                mode_next   = sed_pkg::MODE_NORMAL;
                acc_next    = '0;
                digits_next = '0;
                stop_next   = 1'b0;
                unique case (s1_byte_reg) inside
                    sed_pkg::CH_A:
                    begin
                        res[rn[1:0]] = sed_pkg::BEL;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_B:
                    begin
                        res[rn[1:0]] = sed_pkg::BS;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_T:
                    begin
                        res[rn[1:0]] = sed_pkg::HT;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_N:
                    begin
                        res[rn[1:0]] = sed_pkg::LF;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_V:
                    begin
                        res[rn[1:0]] = sed_pkg::VT;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_F:
                    begin
                        res[rn[1:0]] = sed_pkg::FF;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_R:
                    begin
                        res[rn[1:0]] = sed_pkg::CR;
                        rn = rn + 3'd1;
                    end
                    sed_pkg::CH_X:
                    begin
                        mode_next = sed_pkg::MODE_HEX_X;
                    end
                    sed_pkg::CH_U:
                    begin
                        mode_next = sed_pkg::MODE_U_START;
                    end
                    [sed_pkg::CH_0:sed_pkg::CH_7]:
                    begin
                        acc_next    = {29'b0, s1_byte_reg[2:0]};
                        digits_next = 4'd1;
                        mode_next   = sed_pkg::MODE_OCT;
                    end
                    default:
                    begin
                        res[rn[1:0]] = s1_byte_reg;
                        rn = rn + 3'd1;
                    end
                endcase
            end

            sed_pkg::MODE_HEX_X:
            begin
                if (!stop_reg && hx.ok)
                    acc_next = {acc_reg[27:0], hx.val};
                else
                    stop_next = 1'b1;
                digits_next = digits_reg + 4'd1;
                if (digits_next >= sed_pkg::HEX_X_DIGITS)
                begin
                    res[rn[1:0]] = acc_next[7:0];
                    rn          = rn + 3'd1;
                    mode_next   = sed_pkg::MODE_NORMAL;
                    acc_next    = '0;
                    digits_next = '0;
                    stop_next   = 1'b0;
                end
            end

            sed_pkg::MODE_OCT:
            begin
                if (s1_byte_reg >= sed_pkg::CH_0 && s1_byte_reg <= sed_pkg::CH_7)
                begin
                    acc_next    = {acc_reg[28:0], 3'b000} + {29'b0, s1_byte_reg[2:0]};
                    digits_next = digits_reg + 4'd1;
                    if (digits_next >= sed_pkg::OCT_DIGITS)
                    begin
                        res[rn[1:0]] = acc_next[7:0];
                        rn          = rn + 3'd1;
                        mode_next   = sed_pkg::MODE_NORMAL;
                        acc_next    = '0;
                        digits_next = '0;
                        stop_next   = 1'b0;
                    end
                end
                else
                begin
                    res[rn[1:0]] = acc_reg[7:0];
                    rn          = rn + 3'd1;
                    mode_next   = sed_pkg::MODE_NORMAL;
                    acc_next    = '0;
                    digits_next = '0;
                    stop_next   = 1'b0;
                    if (s1_byte_reg == sed_pkg::CH_BSLASH)
                        mode_next = sed_pkg::MODE_ESC;
                    else
                    begin
                        res[rn[1:0]] = s1_byte_reg;
                        rn = rn + 3'd1;
                    end
                end
            end

            sed_pkg::MODE_U_START:
            begin
                acc_next    = '0;
                digits_next = '0;
                stop_next   = 1'b0;
                if (s1_byte_reg == sed_pkg::CH_LBRACE)
                    mode_next = sed_pkg::MODE_U_BRACE;
                else
                begin
                    mode_next = sed_pkg::MODE_U_FOUR;
                    if (hx.ok)
                        acc_next = {28'b0, hx.val};
                    else
                        stop_next = 1'b1;
                    digits_next = 4'd1;
                end
            end

            sed_pkg::MODE_U_FOUR:
            begin
                if (!stop_reg && hx.ok)
                    acc_next = {acc_reg[27:0], hx.val};
                else
                    stop_next = 1'b1;
                digits_next = digits_reg + 4'd1;
                if (digits_next >= sed_pkg::U_FOUR_DIGITS)
                begin
                    enc = sed_pkg::utf8_enc(acc_next);
                    for (int i = 0; i < sed_pkg::MAX_RESULTS; i++)
                    begin
                        if (3'(i) < enc.len)
                        begin
                            res[rn[1:0]] = enc.b[i];
                            rn = rn + 3'd1;
                        end
                    end
                    mode_next   = sed_pkg::MODE_NORMAL;
                    acc_next    = '0;
                    digits_next = '0;
                    stop_next   = 1'b0;
                end
            end

            sed_pkg::MODE_U_BRACE:
            begin
                if (digits_reg < sed_pkg::MAX_BRACE_DIGITS && hx.ok)
                begin
                    acc_next    = {acc_reg[27:0], hx.val};
                    digits_next = digits_reg + 4'd1;
                end
                else
                begin
                    // closing byte is swallowed whatever it is
                    enc = sed_pkg::utf8_enc(acc_reg);
                    for (int i = 0; i < sed_pkg::MAX_RESULTS; i++)
                    begin
                        if (3'(i) < enc.len)
                        begin
                            res[rn[1:0]] = enc.b[i];
                            rn = rn + 3'd1;
                        end
                    end
                    mode_next   = sed_pkg::MODE_NORMAL;
                    acc_next    = '0;
                    digits_next = '0;
                    stop_next   = 1'b0;
                end
            end

            default:
            begin
                mode_next   = sed_pkg::MODE_NORMAL;
                acc_next    = '0;
                digits_next = '0;
                stop_next   = 1'b0;
                if (s1_byte_reg == sed_pkg::CH_BSLASH)
                    mode_next = sed_pkg::MODE_ESC;
                else
                begin
                    res[rn[1:0]] = s1_byte_reg;
                    rn = rn + 3'd1;
                end
            end
        endcase

        // end of string: flush pending octal, drop any other open escape
        if (s1_eos_reg)
        begin
            if (mode_next == sed_pkg::MODE_OCT)
            begin
                res[rn[1:0]] = acc_next[7:0];
                rn = rn + 3'd1;
            end
            mode_next   = sed_pkg::MODE_NORMAL;
            acc_next    = '0;
            digits_next = '0;
            stop_next   = 1'b0;
        end
    end

    always_comb
    begin
        if (load)
        begin
            cnt_next = rn;
            buf_next = res;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
            buf_next = buf_reg >> 8;
        end
        else
        begin
            cnt_next = cnt_reg;
            buf_next = buf_reg;
        end
        s1_valid_next = text.ready ? text.valid : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            mode_reg     <= sed_pkg::MODE_NORMAL;
            acc_reg      <= '0;
            digits_reg   <= '0;
            stop_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            cnt_reg      <= cnt_next;
            if (load)
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                digits_reg <= digits_next;
                stop_reg   <= stop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (text.valid && text.ready)
        begin
            s1_byte_reg <= text.in_byte;
            s1_eos_reg  <= text.end_of_string;
        end
    end

endmodule

// ===== hdl/sed_checker.sv =====
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks of the string escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("output word changed while stalled");

    // no output word after a reset edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // empty result buffer never blocks the input
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no output pending");

    // a run continues until its last byte
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("result run cut short");

    // input stalls only while the output cannot retire its last word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !(out_ready && run_last))
        else $error("input stalled while the output could advance");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_byte  (decoded.out_byte),
    .run_last  (decoded.run_last)
);
